@@ sv/assert_macros.svh @@
// Assertion macros shared by the lunar date converter RTL.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check with active-low reset disable
`define GLC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("glc assertion failed");

// same, using the module's standard clock and reset names
`define GLC_ASSERT_STD(lbl, prop) `GLC_ASSERT(lbl, i_clk, i_rst_n, prop)

`endif

@@ sv/glc_pkg.sv @@
// Package for the Gregorian to lunar date converter.
// Year ROM, month start table, state and result types. No dependencies.
`default_nettype none

package glc_pkg;

    localparam int TABLE_YEARS = 32;
    localparam logic [11:0] FIRST_TABLE_YEAR = 12'd2019;
    localparam logic [11:0] FIRST_YEAR = 12'd2020;
    localparam logic [11:0] LAST_YEAR = 12'd2050;
    localparam logic [11:0] CYCLE_BASE = 12'd1984;
    localparam logic [4:0] SHORT_MONTH = 5'h1d;
    localparam logic [4:0] LONG_MONTH = 5'h1e;

    // leap[23:20], long bits months 1..13 [19:7], new year month [6:5], day [4:0]
    localparam logic [23:0] YEAR_ROM [TABLE_YEARS] = '{
        24'h0A9345, 24'h474AB9, 24'h06AA4C, 24'h0AD541,
        24'h24DAB6, 24'h04B64A, 24'h69573D, 24'h0A4E51,
        24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43,
        24'h36B537, 24'h096D4B, 24'hB4AEBF, 24'h04AD53,
        24'h0A4D48, 24'h6D25BC, 24'h0D254F, 24'h0D5244,
        24'h5DAA38, 24'h0B5A4C, 24'h056D41, 24'h24ADB6,
        24'h049B4A, 24'h7A4BBE, 24'h0A4B51, 24'h0AA546,
        24'h5B52BA, 24'h06D24E, 24'h0ADA42, 24'h355B37
    };

    localparam logic [8:0] MONTH_START [12] = '{
        9'h000, 9'h01f, 9'h03b, 9'h05a, 9'h078, 9'h097,
        9'h0b5, 9'h0d4, 9'h0f3, 9'h111, 9'h130, 9'h14e
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_BINIT,
        S_WALK,
        S_BFIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [11:0] cal_year;
        logic [3:0]  cal_month;
        logic [4:0]  cal_day;
        logic        leap_month;
        logic [5:0]  cycle_index;
        logic        in_range;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

    typedef struct packed {
        logic [8:0] diff;
        logic       ge;
        logic       gt;
    } t_sub_out;

    function automatic logic [4:0] month_len(input logic [4:0] row, input logic [3:0] m);
        logic [12:0] bits;
        bits = YEAR_ROM[row][19:7];
        if (m < 4'd1 || m > 4'd13) begin
            return SHORT_MONTH;
        end
        return bits[4'd13 - m] ? LONG_MONTH : SHORT_MONTH;
    endfunction

endpackage

`default_nettype wire

@@ sv/gregorian_to_lunar_date_top.sv @@
// Gregorian to Chinese lunar date converter, top level with stream ports.
// After the input transaction the core steps SPLIT, WALK (once per month step through
// the shared subtractor), DONE on or after new year, SPLIT, BINIT, WALK, BFIN, DONE
// before it, and straight to DONE for dates that do not convert. One date in work at
// a time; the result is registered to the output once it is free. Sync active-low reset
// clears the sequencer and output valid. Depends on glc_pkg, glc_core and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gregorian_to_lunar_date_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // greg_year[11:0], greg_month[15:12], greg_day[20:16]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // cal_year[11:0], cal_month[15:12], cal_day[20:16], leap_month[21],
    // cycle_index[27:22], in_range[28]
    output logic [31:0]      o_m_tdata
);
    import glc_pkg::*;

    t_core_stat w_stat;
    t_result    w_res;
    logic       w_take;
    logic       r_m_valid, n_m_valid;
    t_result    r_m_res, n_m_res;

    assign o_s_tready = w_stat.idle;
    assign w_take = w_stat.done && (!r_m_valid || i_m_tready);

    glc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_s_tvalid && w_stat.idle),
        .i_year  (i_s_tdata[11:0]),
        .i_month (i_s_tdata[15:12]),
        .i_day   (i_s_tdata[20:16]),
        .i_take  (w_take),
        .o_stat  (w_stat),
        .o_res   (w_res)
    );

    always_comb begin
        n_m_valid = r_m_valid;
        n_m_res = r_m_res;
        if (w_take) begin
            n_m_valid = 1'b1;
            n_m_res = w_res;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
        r_m_res <= n_m_res;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata = {3'b000, r_m_res.in_range, r_m_res.cycle_index, r_m_res.leap_month,
                        r_m_res.cal_day, r_m_res.cal_month, r_m_res.cal_year};

    `GLC_ASSERT_STD(a_out_from_core, $rose(r_m_valid) |-> $past(w_stat.done))
    `GLC_ASSERT_STD(a_ready_idle, o_s_tready |-> !w_stat.done)
    `GLC_ASSERT_STD(a_take_loads, w_take |=> r_m_valid)

endmodule

`default_nettype wire

@@ sv/glc_sub.sv @@
// Shared subtract and compare unit of the lunar date converter.
// Depends on glc_pkg for the result struct.
`default_nettype none

module glc_sub (
    input  wire logic [8:0]       i_a,
    input  wire logic [8:0]       i_b,
    output glc_pkg::t_sub_out     o_res
);
    import glc_pkg::*;

    logic [9:0] w_full;

    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.diff = w_full[8:0];
    assign o_res.ge = ~w_full[9];
    assign o_res.gt = ~w_full[9] && (w_full[8:0] != 9'd0);

endmodule

`default_nettype wire

@@ sv/glc_core.sv @@
// Sequencer and datapath of the lunar date converter.
// Depends on glc_pkg, glc_sub and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module glc_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [11:0]   i_year,
    input  wire logic [3:0]    i_month,
    input  wire logic [4:0]    i_day,
    input  wire logic          i_take,
    output glc_pkg::t_core_stat o_stat,
    output glc_pkg::t_result   o_res
);
    import glc_pkg::*;

    t_state      r_state, n_state;
    logic        r_valid, n_valid;
    logic        r_fwd, n_fwd;
    logic [11:0] r_year, n_year;
    logic [4:0]  r_row, n_row;
    logic [8:0]  r_rem, n_rem;
    logic [7:0]  r_nyoff, n_nyoff;
    logic [3:0]  r_mon, n_mon;
    logic [3:0]  r_mp, n_mp;
    logic        r_toggle, n_toggle;
    logic        r_lflag, n_lflag;
    t_result     r_res, n_res;

    logic        w_in_ok;
    logic [4:0]  w_in_row;
    logic [7:0]  w_b2;
    logic [7:0]  w_nyoff;
    logic [8:0]  w_doff;
    logic [4:0]  w_len;
    logic [3:0]  w_leap;
    logic [3:0]  w_prev_leap;
    logic [8:0]  w_a, w_b;
    t_sub_out    w_sub;
    logic [3:0]  w_mon_b;
    logic        w_tog_b;
    logic        w_lf_b;
    logic [6:0]  w_cyc_raw;
    logic [5:0]  w_cyc;

    assign w_in_ok = (i_year >= FIRST_YEAR) && (i_year <= LAST_YEAR) && (i_month >= 4'd1)
        && (i_month <= 4'd12) && (i_day != 5'd0);
    assign w_in_row = w_in_ok ? 5'(i_year - FIRST_TABLE_YEAR) : 5'd0;
    assign w_b2 = YEAR_ROM[w_in_row][7:0];
    assign w_nyoff = (w_b2[6:5] == 2'd1) ? ({3'b0, w_b2[4:0]} - 8'd1)
                                         : ({3'b0, w_b2[4:0]} + 8'd30);
    assign w_doff = MONTH_START[i_month - 4'd1] + {4'b0, i_day} - 9'd1
        + {8'b0, (i_month > 4'd2) && (i_year[1:0] == 2'b00)};

    assign w_len = month_len(r_row, r_mp);
    assign w_leap = YEAR_ROM[r_row][23:20];
    assign w_prev_leap = YEAR_ROM[r_row - 5'd1][23:20];

    assign w_cyc_raw = 7'(r_year - CYCLE_BASE);
    assign w_cyc = (w_cyc_raw >= 7'd60) ? 6'(w_cyc_raw - 7'd60) : w_cyc_raw[5:0];

    // backward step of the month counter and leap flag
    always_comb begin
        w_mon_b = r_toggle ? r_mon : r_mon - 4'd1;
        w_tog_b = r_toggle;
        w_lf_b = r_lflag;
        if (w_mon_b == w_leap) begin
            w_tog_b = ~r_toggle;
            w_lf_b = 1'b1;
        end
        if (!w_tog_b) begin
            w_lf_b = 1'b0;
        end
    end

    always_comb begin
        case (r_state)
            S_SPLIT: begin
                w_a = r_rem;
                w_b = {1'b0, r_nyoff};
            end
            S_BINIT: begin
                w_a = {1'b0, r_nyoff};
                w_b = r_rem;
            end
            S_WALK: begin
                w_a = r_rem;
                w_b = {4'b0, w_len};
            end
            S_BFIN: begin
                w_a = {4'b0, w_len};
                w_b = r_rem;
            end
            default: begin
                w_a = r_rem;
                w_b = r_rem;
            end
        endcase
    end

    glc_sub u_sub (
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_sub)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = w_in_ok ? S_SPLIT : S_DONE;
                end
            end
            S_SPLIT: n_state = w_sub.ge ? S_WALK : S_BINIT;
            S_BINIT: n_state = S_WALK;
            S_WALK: begin
                if (r_fwd) begin
                    n_state = w_sub.ge ? S_WALK : S_DONE;
                end else begin
                    n_state = w_sub.gt ? S_WALK : S_BFIN;
                end
            end
            S_BFIN: n_state = S_DONE;
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_fwd = r_fwd;
        n_year = r_year;
        n_row = r_row;
        n_rem = r_rem;
        n_nyoff = r_nyoff;
        n_mon = r_mon;
        n_mp = r_mp;
        n_toggle = r_toggle;
        n_lflag = r_lflag;
        n_res = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_valid = w_in_ok;
                    n_year = i_year;
                    n_row = w_in_row;
                    n_rem = w_doff;
                    n_nyoff = w_nyoff;
                    n_res = '0;
                end
            end
            S_SPLIT: begin
                n_toggle = 1'b0;
                n_lflag = 1'b0;
                if (w_sub.ge) begin
                    n_fwd = 1'b1;
                    n_rem = w_sub.diff;
                    n_mon = 4'd1;
                    n_mp = 4'd1;
                end else begin
                    n_fwd = 1'b0;
                    n_row = r_row - 5'd1;
                    n_year = r_year - 12'd1;
                    n_mon = 4'd12;
                    n_mp = (w_prev_leap == 4'd0) ? 4'd12 : 4'd13;
                end
            end
            S_BINIT: n_rem = w_sub.diff;
            S_WALK: begin
                if (r_fwd) begin
                    if (w_sub.ge) begin
                        n_rem = w_sub.diff;
                        n_mp = r_mp + 4'd1;
                        if (r_mon == w_leap) begin
                            n_toggle = ~r_toggle;
                            if (r_toggle) begin
                                n_mon = r_mon + 4'd1;
                                n_lflag = 1'b0;
                            end else begin
                                n_lflag = 1'b1;
                            end
                        end else begin
                            n_mon = r_mon + 4'd1;
                        end
                    end else begin
                        n_res.cal_year = r_year;
                        n_res.cal_month = r_mon;
                        n_res.cal_day = 5'(r_rem + 9'd1);
                        n_res.leap_month = r_lflag;
                        n_res.cycle_index = w_cyc;
                        n_res.in_range = 1'b1;
                    end
                end else if (w_sub.gt) begin
                    n_rem = w_sub.diff;
                    n_mp = r_mp - 4'd1;
                    n_mon = w_mon_b;
                    n_toggle = w_tog_b;
                    n_lflag = w_lf_b;
                end
            end
            S_BFIN: begin
                n_res.cal_year = r_year;
                n_res.cal_month = r_mon;
                n_res.cal_day = 5'(w_sub.diff + 9'd1);
                n_res.leap_month = r_lflag || ((r_mon == 4'd12) && (w_leap == 4'd12));
                n_res.cycle_index = w_cyc;
                n_res.in_range = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_fwd <= n_fwd;
        r_year <= n_year;
        r_row <= n_row;
        r_rem <= n_rem;
        r_nyoff <= n_nyoff;
        r_mon <= n_mon;
        r_mp <= n_mp;
        r_toggle <= n_toggle;
        r_lflag <= n_lflag;
        r_res <= n_res;
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_res = r_res;

    `GLC_ASSERT_STD(a_walk_valid, (r_state == S_WALK) |-> r_valid)
    `GLC_ASSERT_STD(a_split_next,
        (r_state == S_SPLIT) |=> (r_state == S_WALK || r_state == S_BINIT))
    `GLC_ASSERT_STD(a_done_fields, (r_state == S_DONE && r_res.in_range)
        |-> (r_res.cal_day != 5'd0 && r_res.cal_month != 4'd0))

endmodule

`default_nettype wire

@@ bench/tb_gregorian_to_lunar_date_top.sv @@
// Self-checking bench for gregorian_to_lunar_date_top: stream stimulus with random gaps,
// a table-driven lunar date predictor and an in-order result scoreboard.
// Depends only on the gregorian_to_lunar_date_top RTL and its package.

module tb_gregorian_to_lunar_date_top;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned ROW_BASE_YEAR = 2019;
    localparam int unsigned CYCLE_BASE_YEAR = 1984;
    localparam int unsigned SHORT_DAYS = 29;
    localparam int unsigned LONG_DAYS = 30;

    // per lunar year: leap month | long bits 1..4, long bits 5..12, bit 13 | ny month | ny day
    localparam logic [7:0] YEAR_TABLE [96] = '{
        8'h0A, 8'h93, 8'h45, 8'h47, 8'h4A, 8'hB9, 8'h06, 8'hAA, 8'h4C, 8'h0A, 8'hD5, 8'h41,
        8'h24, 8'hDA, 8'hB6, 8'h04, 8'hB6, 8'h4A, 8'h69, 8'h57, 8'h3D, 8'h0A, 8'h4E, 8'h51,
        8'h0D, 8'h26, 8'h46, 8'h5E, 8'h93, 8'h3A, 8'h0D, 8'h53, 8'h4D, 8'h05, 8'hAA, 8'h43,
        8'h36, 8'hB5, 8'h37, 8'h09, 8'h6D, 8'h4B, 8'hB4, 8'hAE, 8'hBF, 8'h04, 8'hAD, 8'h53,
        8'h0A, 8'h4D, 8'h48, 8'h6D, 8'h25, 8'hBC, 8'h0D, 8'h25, 8'h4F, 8'h0D, 8'h52, 8'h44,
        8'h5D, 8'hAA, 8'h38, 8'h0B, 8'h5A, 8'h4C, 8'h05, 8'h6D, 8'h41, 8'h24, 8'hAD, 8'hB6,
        8'h04, 8'h9B, 8'h4A, 8'h7A, 8'h4B, 8'hBE, 8'h0A, 8'h4B, 8'h51, 8'h0A, 8'hA5, 8'h46,
        8'h5B, 8'h52, 8'hBA, 8'h06, 8'hD2, 8'h4E, 8'h0A, 8'hDA, 8'h42, 8'h35, 8'h5B, 8'h37
    };

    localparam int unsigned DAYS_BEFORE_MONTH [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    typedef struct {
        logic [11:0] cal_year;
        logic [3:0]  cal_month;
        logic [4:0]  cal_day;
        logic        leap_month;
        logic [5:0]  cycle_index;
        logic        in_range;
    } t_lunar_date;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;    // greg_year[11:0], greg_month[15:12], greg_day[20:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // cal_year[11:0], cal_month[15:12], cal_day[20:16], leap_month[21],
    // cycle_index[27:22], in_range[28]
    logic [31:0] m_tdata;

    t_lunar_date pending_dates [$];
    int unsigned cycle_count = 0;
    int          fail_count = 0;
    int          rx_hold_cycles = 0;
    bit          tx_gap_off = 1'b0;
    bit          rx_stall_off = 1'b0;

    gregorian_to_lunar_date_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned lunar_month_days(input int unsigned row,
                                                     input int unsigned slot);
        logic [12:0] long_bits;
        long_bits = {YEAR_TABLE[row*3][3:0], YEAR_TABLE[row*3+1], YEAR_TABLE[row*3+2][7]};
        if (slot < 1 || slot > 13) begin
            return SHORT_DAYS;
        end
        return long_bits[13 - slot] ? LONG_DAYS : SHORT_DAYS;
    endfunction

    function automatic t_lunar_date convert_to_lunar(input logic [11:0] gy,
                                                     input logic [3:0] gm,
                                                     input logic [4:0] gd);
        t_lunar_date r;
        int unsigned year, row, ny_off, doff, back_days, leap, len, slot, mon, day;
        logic [7:0] ny_byte;
        bit toggle, lflag;
        r = '{default: '0};
        toggle = 1'b0;
        lflag = 1'b0;
        if (gy < 2020 || gy > 2050 || gm < 1 || gm > 12 || gd == 0) begin
            return r;
        end
        year = gy;
        row = year - ROW_BASE_YEAR;
        ny_byte = YEAR_TABLE[row*3+2];
        if (ny_byte[6:5] == 2'd1) begin
            ny_off = (int'(ny_byte[4:0]) - 1) & 8'hff;
        end else begin
            ny_off = (int'(ny_byte[4:0]) + 30) & 8'hff;
        end
        doff = DAYS_BEFORE_MONTH[gm - 1] + gd - 1;
        if (gm > 2 && (year % 4) == 0) begin
            doff += 1;
        end
        if (doff >= ny_off) begin
            doff -= ny_off;
            mon = 1;
            slot = 1;
            len = lunar_month_days(row, slot);
            leap = YEAR_TABLE[row*3] >> 4;
            while (doff >= len) begin
                doff -= len;
                slot += 1;
                if (mon == leap) begin
                    toggle = !toggle;
                    if (!toggle) begin
                        mon += 1;
                        lflag = 1'b0;
                    end else begin
                        lflag = 1'b1;
                    end
                end else begin
                    mon += 1;
                end
                len = lunar_month_days(row, slot);
            end
            day = doff + 1;
        end else begin
            // before new year: walk back from the last month of the prior lunar year
            back_days = ny_off - doff;
            year -= 1;
            row -= 1;
            mon = 12;
            leap = YEAR_TABLE[row*3] >> 4;
            slot = (leap == 0) ? 12 : 13;
            len = lunar_month_days(row, slot);
            while (back_days > len) begin
                back_days -= len;
                slot -= 1;
                if (!toggle) begin
                    mon -= 1;
                end
                if (mon == leap) begin
                    toggle = !toggle;
                    lflag = 1'b1;
                end
                if (!toggle) begin
                    lflag = 1'b0;
                end
                len = lunar_month_days(row, slot);
            end
            day = len - back_days + 1;
            if (mon == 12 && leap == 12) begin
                lflag = 1'b1;
            end
        end
        r.cal_year = year[11:0];
        r.cal_month = mon[3:0];
        r.cal_day = day[4:0];
        r.leap_month = lflag;
        r.cycle_index = 6'((year - CYCLE_BASE_YEAR) % 60);
        r.in_range = 1'b1;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_date(input logic [11:0] gy, input logic [3:0] gm, input logic [4:0] gd);
        int gap;
        gap = tx_gap_off ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, gd, gm, gy};
        do @(posedge i_clk); while (!s_tready);
        pending_dates.push_back(convert_to_lunar(gy, gm, gd));
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic send_random_date();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            send_date(12'($urandom_range(2020, 2050)), 4'($urandom_range(1, 12)),
                      5'($urandom_range(1, 31)));
        end else if (kind < 80) begin
            // around lunar new year, where both walks are exercised
            send_date(12'($urandom_range(2020, 2050)), 4'($urandom_range(1, 2)),
                      5'($urandom_range(1, 31)));
        end else if (kind < 90) begin
            send_date(12'($urandom_range(2020, 2050)), 4'($urandom_range(0, 15)),
                      5'($urandom_range(0, 31)));
        end else begin
            send_date(12'($urandom), 4'($urandom), 5'($urandom));
        end
    endtask

    task automatic test_directed();
        send_date(12'd2020, 4'd1, 5'd1);
        send_date(12'd2050, 4'd12, 5'd31);
        send_date(12'd2019, 4'd6, 5'd15);
        send_date(12'd2051, 4'd1, 5'd1);
        send_date(12'd0, 4'd0, 5'd0);
        send_date(12'd4095, 4'd15, 5'd31);
        send_date(12'd2030, 4'd0, 5'd10);
        send_date(12'd2030, 4'd13, 5'd10);
        send_date(12'd2030, 4'd5, 5'd0);
        send_date(12'd2020, 4'd1, 5'd25);
        send_date(12'd2020, 4'd1, 5'd24);
        send_date(12'd2020, 4'd2, 5'd29);
        send_date(12'd2020, 4'd3, 5'd1);
        send_date(12'd2021, 4'd3, 5'd1);
        send_date(12'd2021, 4'd2, 5'd31);
        send_date(12'd2020, 4'd5, 5'd23);
        send_date(12'd2020, 4'd6, 5'd21);
        send_date(12'd2023, 4'd3, 5'd22);
        send_date(12'd2024, 4'd2, 5'd9);
        send_date(12'd2025, 4'd7, 5'd25);
        send_date(12'd2033, 4'd12, 5'd22);
        send_date(12'd2034, 4'd1, 5'd15);
        send_date(12'd2049, 4'd12, 5'd31);
        send_date(12'd2050, 4'd1, 5'd1);
    endtask

    task automatic test_random_dates(input int count);
        repeat (count) send_random_date();
    endtask

    task automatic test_back_to_back();
        tx_gap_off = 1'b1;
        rx_stall_off = 1'b1;
        repeat (50) send_random_date();
        tx_gap_off = 1'b0;
        rx_stall_off = 1'b0;
    endtask

    task automatic test_output_hold_off();
        rx_hold_cycles = 300;
        tx_gap_off = 1'b1;
        repeat (30) send_random_date();
        tx_gap_off = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (25) send_random_date();
        stop_sending();
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (25) send_random_date();
    endtask

    // receiver: random stalls, or a long counted hold-off on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (rx_stall_off) begin
                m_tready <= 1'b1;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                stall = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
                m_tready <= (stall == 0);
                if (stall > 0) begin
                    stall--;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_lunar_date exp_date;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_dates.size() == 0) begin
                $error("unexpected result transaction, data %h", m_tdata);
                fail_count++;
            end else begin
                exp_date = pending_dates.pop_front();
                check_field("cal_year", exp_date.cal_year, m_tdata[11:0]);
                check_field("cal_month", exp_date.cal_month, m_tdata[15:12]);
                check_field("cal_day", exp_date.cal_day, m_tdata[20:16]);
                check_field("leap_month", exp_date.leap_month, m_tdata[21]);
                check_field("cycle_index", exp_date.cycle_index, m_tdata[27:22]);
                check_field("in_range", exp_date.in_range, m_tdata[28]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_dates(420);
        test_back_to_back();
        test_output_hold_off();
        test_drain_pause();
        stop_sending();
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
